@@ rtl/aeg_pkg.sv @@
// shared constants and widths for the adaptive energy gate
`timescale 1ns / 1ps

package aeg_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CHUNK_MAX = 1024;
  localparam int COUNT_W   = $clog2(CHUNK_MAX + 1);
  localparam int SUM_W     = 41;
  localparam int FLOOR_W   = 32;
  localparam int LEVEL_W   = 15;
  localparam int ALPHA_W   = 16;
  localparam int MULT_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int OUT_DAT_W = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MULT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_MIN      = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 16'd1311;
  localparam logic [MULT_W-1:0]  MULT_RESET    = 12'd410;
  localparam logic [LEVEL_W-1:0] ABS_MIN_RESET = 15'd39;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7fff;

endpackage

@@ rtl/adaptive_energy_gate.sv @@
// chunked rms energy detector with adaptive noise floor and gate output
//
//  port group  dir  beat contents
//  in_*        in   tdata: sample[15:0]; tlast: last_of_chunk
//  out_*       out  tdata: rms_level[14:0], noise_floor[29:15], zero[31:30]; tuser: gate_flag
//  cfg_*       in   cfg_index selects floor_alpha / trigger_multiplier / absolute_min_level
//
//  a sample beat steps through accept, square on the shared multiplier, accumulate
//  a chunk-end beat adds a restoring divide and a square root on the shared subtractor,
//  then seeds, tests the threshold, runs the ema if the gate stays shut and loads the result
//  into the output register to wait; the next chunk end stalls only if it is still full
//  rst_n is synchronous; it restores register defaults and unseeds the noise floor
`timescale 1ns / 1ps

module adaptive_energy_gate (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [aeg_pkg::SAMPLE_W-1:0]    in_tdata,   // sample
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [aeg_pkg::OUT_DAT_W-1:0]   out_tdata,  // rms_level, noise_floor, zero pad
  output logic                            out_tuser,  // gate_flag
  input  logic                            cfg_we,
  input  logic [aeg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aeg_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  import aeg_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [ST_W-1:0] S_SQ   = 4'd1;
  localparam logic [ST_W-1:0] S_ACC  = 4'd2;
  localparam logic [ST_W-1:0] S_DIV  = 4'd3;
  localparam logic [ST_W-1:0] S_SQRT = 4'd4;
  localparam logic [ST_W-1:0] S_SEED = 4'd5;
  localparam logic [ST_W-1:0] S_THR  = 4'd6;
  localparam logic [ST_W-1:0] S_CMP  = 4'd7;
  localparam logic [ST_W-1:0] S_EMA1 = 4'd8;
  localparam logic [ST_W-1:0] S_EMA2 = 4'd9;
  localparam logic [ST_W-1:0] S_EMA3 = 4'd10;
  localparam logic [ST_W-1:0] S_OUT  = 4'd11;

  localparam int MUL_A_W = ALPHA_W + 1;
  localparam int MUL_P_W = MUL_A_W + FLOOR_W;
  localparam int SUB_W   = 19;
  localparam int ROOT_W  = 16;
  localparam int STEP_W  = 6;
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  logic [ST_W-1:0]      state_r, state_nxt;
  logic [ALPHA_W-1:0]   alpha_r;
  logic [MULT_W-1:0]    mult_r;
  logic [LEVEL_W-1:0]   abs_min_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic                 last_r;
  logic [SUM_W-1:0]     sum_r;
  logic [COUNT_W-1:0]   count_r;
  logic [FLOOR_W-1:0]   floor_r;
  logic                 seeded_r;
  logic [STEP_W-1:0]    step_r;
  logic [SUB_W-1:0]     rem_r;
  logic [ROOT_W-1:0]    root_r;
  logic [LEVEL_W-1:0]   rms_r;
  logic [MUL_P_W-1:0]   prod_r;
  logic [MUL_P_W-1:0]   acc_r;
  logic                 gate_held_r;
  logic                 out_tvalid_r;
  logic [OUT_DAT_W-1:0] out_tdata_r;
  logic                 out_tuser_r;

  logic [SAMPLE_W-1:0]  mag;
  logic [MUL_A_W-1:0]   mul_a;
  logic [FLOOR_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;
  logic [SUB_W-1:0]     sub_a, sub_b;
  logic [SUB_W:0]       sub_d;
  logic                 sub_ge;
  logic                 gate;
  logic [MUL_P_W-1:0]   ema_sum;
  logic [LEVEL_W-1:0]   nf_level;
  logic [LEVEL_W-1:0]   root_level;
  logic                 chunk_end;
  logic                 out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // magnitude; the most negative sample gives 2^15 as unsigned
  assign mag = sample_r[SAMPLE_W-1] ? (~sample_r + SAMPLE_W'(1)) : sample_r;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ: begin
        mul_a = MUL_A_W'(mag);
        mul_b = FLOOR_W'(mag);
      end
      S_THR: begin
        mul_a = MUL_A_W'(mult_r);
        mul_b = floor_r;
      end
      S_EMA1: begin
        mul_a = (MUL_A_W'(1) << ALPHA_W) - MUL_A_W'(alpha_r);
        mul_b = floor_r;
      end
      S_EMA2: begin
        mul_a = MUL_A_W'(alpha_r);
        mul_b = {1'b0, rms_r, 16'b0};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // shared subtractor: divide remainder step or square root trial
  always_comb begin
    if (state_r == S_DIV) begin
      sub_a = SUB_W'({rem_r[COUNT_W-1:0], sum_r[SUM_W-1]});
      sub_b = SUB_W'(count_r);
    end else begin
      sub_a = {rem_r[ROOT_W:0], sum_r[31:30]};
      sub_b = SUB_W'({root_r, 2'b01});
    end
  end
  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~sub_d[SUB_W];

  // root reaches 2^15 only for a full-scale negative chunk
  assign root_level = root_r[ROOT_W-1] ? LEVEL_MAX : root_r[LEVEL_W-1:0];

  assign chunk_end = last_r || (count_r == COUNT_W'(CHUNK_MAX));
  assign gate      = ({5'b0, rms_r, 24'b0} > prod_r[43:0]) && (rms_r > abs_min_r);
  assign ema_sum   = acc_r + prod_r + MUL_P_W'(32768);
  assign nf_level  = floor_r[FLOOR_W-1] ? LEVEL_MAX : floor_r[30:16];
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ACC;
      S_ACC:  state_nxt = chunk_end ? S_DIV : S_IDLE;
      S_DIV:  if (step_r == DIV_LAST) state_nxt = S_SQRT;
      S_SQRT: if (step_r == SQRT_LAST) state_nxt = S_SEED;
      S_SEED: state_nxt = S_THR;
      S_THR:  state_nxt = S_CMP;
      S_CMP:  state_nxt = gate ? S_OUT : S_EMA1;
      S_EMA1: state_nxt = S_EMA2;
      S_EMA2: state_nxt = S_EMA3;
      S_EMA3: state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      alpha_r      <= ALPHA_RESET;
      mult_r       <= MULT_RESET;
      abs_min_r    <= ABS_MIN_RESET;
      sum_r        <= '0;
      count_r      <= '0;
      floor_r      <= '0;
      seeded_r     <= 1'b0;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FLOOR_ALPHA:  alpha_r   <= cfg_wdata[ALPHA_W-1:0];
          REG_TRIGGER_MULT: mult_r    <= cfg_wdata[MULT_W-1:0];
          REG_ABS_MIN:      abs_min_r <= cfg_wdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && out_free) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) count_r <= count_r + COUNT_W'(1);
          step_r <= '0;
        end
        S_ACC:  sum_r <= sum_r + SUM_W'(prod_r[31:0]);
        S_DIV: begin
          // quotient bits shift into the bottom of the sum register
          sum_r  <= {sum_r[SUM_W-2:0], sub_ge};
          step_r <= (step_r == DIV_LAST) ? '0 : step_r + STEP_W'(1);
        end
        S_SQRT: begin
          sum_r  <= (step_r == SQRT_LAST) ? '0 : (sum_r << 2);
          step_r <= step_r + STEP_W'(1);
          if (step_r == SQRT_LAST) count_r <= '0;
        end
        S_SEED: begin
          if (!seeded_r) begin
            floor_r  <= {1'b0, root_level, 16'b0};
            seeded_r <= 1'b1;
          end
        end
        S_EMA3: floor_r <= ema_sum[47:16];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      sample_r <= in_tdata;
      last_r   <= in_tlast;
    end
    if (state_r == S_SQ || state_r == S_THR || state_r == S_EMA2) prod_r <= mul_p;
    if (state_r == S_EMA1) acc_r <= mul_p;
    if (state_r == S_ACC) rem_r <= '0;
    if (state_r == S_DIV) begin
      // the root starts from a clear remainder
      rem_r <= (step_r == DIV_LAST) ? '0 : (sub_ge ? sub_d[SUB_W-1:0] : sub_a);
      if (step_r == DIV_LAST) root_r <= '0;
    end
    if (state_r == S_SQRT) begin
      rem_r  <= sub_ge ? sub_d[SUB_W-1:0] : sub_a;
      root_r <= {root_r[ROOT_W-2:0], sub_ge};
    end
    if (state_r == S_SEED) rms_r <= root_level;
    // gate decision kept from the compare step
    if (state_r == S_CMP) gate_held_r <= gate;
    if (state_r == S_OUT && out_free) begin
      out_tdata_r <= {2'b0, nf_level, rms_r};
      out_tuser_r <= gate_held_r;
    end
  end

  a_seeded_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> seeded_r)
    else $error("result beat before noise floor was seeded");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(CHUNK_MAX))
    else $error("sample count ran past chunk limit");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < SUB_W'(count_r)))
    else $error("divide remainder not below divisor");

endmodule
